// ----- sv/adrc_pkg.sv -----
// Shared types, step codes and constants of the dynamic range compressor.
package adrc_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int LOG_ENTRIES_DEF   = 256;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_IDX_W         = 3;
    localparam int GR_W              = 14;
    localparam int DB_PER_LOG2_Q32   = 25252226;
    localparam int LOG2_PER_DB_Q32   = 11146541;
    localparam int MAX_REDUCTION     = 16383;
    localparam int LEVEL_FLOOR       = -10240;
    localparam int EXP_STEPS         = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_SC      = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_INV_RATIO   = 3'd2,
        REG_KNEE_WIDTH  = 3'd3,
        REG_KNEE_COEFF  = 3'd4,
        REG_ATTACK      = 3'd5,
        REG_RELEASE     = 3'd6,
        REG_MAKEUP      = 3'd7
    } t_reg;

    typedef struct packed {
        logic               use_sc;
        logic signed [14:0] threshold;
        logic [16:0]        inv_ratio;
        logic [12:0]        knee_width;
        logic signed [23:0] knee_coeff;
        logic [23:0]        attack;
        logic [23:0]        release_c;
        logic [23:0]        makeup;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE, OP_NORM, OP_POS, OP_TAB0, OP_TAB1, OP_INTERP, OP_L2, OP_DB, OP_LVL,
        OP_CV1, OP_CV2, OP_CV3, OP_CV4, OP_PK1, OP_PK2, OP_PK3, OP_AT1, OP_AT2,
        OP_AT3, OP_GA1, OP_GA2, OP_EXPM, OP_EXPR, OP_SC1, OP_SC2, OP_SC3, OP_FIN
    } t_op;

    typedef struct packed {
        logic       load;
        t_op        op;
        logic [4:0] k;
    } t_cmd;

    localparam int FRONT_STEPS = 20;
    localparam t_op FRONT_OPS [FRONT_STEPS] = '{
        OP_NORM, OP_POS, OP_TAB0, OP_TAB1, OP_INTERP, OP_L2, OP_DB, OP_LVL,
        OP_CV1, OP_CV2, OP_CV3, OP_CV4, OP_PK1, OP_PK2, OP_PK3,
        OP_AT1, OP_AT2, OP_AT3, OP_GA1, OP_GA2
    };

endpackage

// ----- sv/adrc_ctrl.sv -----
// Compressor sequencer: handshakes, one command per cycle unless stalled.
module adrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output adrc_pkg::t_cmd  o_cmd
);
    import adrc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FRONT = 5'b00010,
        S_EXP   = 5'b00100,
        S_BACK  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cmd       = cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        cmd.load = 1'b0;
        cmd.op   = OP_NONE;
        cmd.k    = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_FRONT;
                    n_cnt    = 5'd0;
                end
            end
            S_FRONT: begin
                cmd.op = FRONT_OPS[r_cnt];
                if (r_cnt == 5'(FRONT_STEPS - 1)) begin
                    n_state = S_EXP;
                    n_cnt   = 5'd1;
                    n_phase = 1'b0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_EXP: begin
                cmd.op  = r_phase ? OP_EXPR : OP_EXPM;
                n_phase = !r_phase;
                if (r_phase) begin
                    if (r_cnt == 5'(EXP_STEPS)) begin
                        n_state = S_BACK;
                        n_cnt   = 5'd0;
                    end else begin
                        n_cnt = r_cnt + 5'd1;
                    end
                end
            end
            S_BACK: begin
                if (r_cnt == 5'd0) begin
                    cmd.op = OP_SC1;
                end else if (r_cnt == 5'd1) begin
                    cmd.op = OP_SC2;
                end else begin
                    cmd.op = OP_SC3;
                end
                if (r_cnt == 5'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.op  = OP_FIN;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = (r_out_valid && !i_out_ready) || (cmd.op == OP_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FIN) |-> out_free)
        else $error("result written over an item not yet taken");
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_FRONT && r_cnt == 5'd0))
        else $error("accepted item did not start the sequence");
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !out_free) |=> (r_state == S_FIN))
        else $error("left final step while output blocked");

endmodule

// ----- sv/adrc_dp.sv -----
// Compressor datapath: level, static curve, smoothing, gain and scaling on one multiplier.
module adrc_dp #(
    parameter int SAMPLE_BITS       = adrc_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_ENTRIES = adrc_pkg::LOG_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  adrc_pkg::t_cmd                i_cmd,
    input  adrc_pkg::t_cfg                i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_main_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_sidechain_sample,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic [adrc_pkg::GR_W-1:0]     o_gain_reduction_db
);
    import adrc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int P_W   = $clog2(SB);

    typedef logic [16:0] t_log_tab [0:LOG_TABLE_ENTRIES];
    typedef logic [30:0] t_root_tab [0:EXP_STEPS];

    function automatic logic [16:0] log2_frac(logic [63:0] v0);
        logic [63:0] v;
        logic [16:0] r;
        v = v0;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            v = (v * v) >> 30;
            if (v >= 64'h8000_0000) begin
                v    = v >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab tb;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
            tb[i] = log2_frac((64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
        end
        tb[LOG_TABLE_ENTRIES] = 17'd65536;
        return tb;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n0);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] pw;
        n   = n0;
        res = '0;
        pw  = 64'd1 << 62;
        while (pw > n) pw = pw >> 2;
        while (pw != 0) begin
            if (n >= res + pw) begin
                n   = n - (res + pw);
                res = (res >> 1) + pw;
            end else begin
                res = res >> 1;
            end
            pw = pw >> 2;
        end
        return res;
    endfunction

    function automatic t_root_tab build_root_tab();
        t_root_tab rt;
        logic [63:0] cur;
        cur   = 64'd1 << 29;
        rt[0] = 31'(cur);
        for (int i = 1; i <= EXP_STEPS; i++) begin
            cur   = isqrt(cur << 30);
            rt[i] = 31'(cur);
        end
        return rt;
    endfunction

    function automatic logic signed [67:0] rnd(logic signed [67:0] v, int s);
        logic [67:0] mag;
        logic [67:0] q;
        mag = (v < 0) ? 68'(-v) : 68'(v);
        q   = (mag + (68'd1 << (s - 1))) >> s;
        return (v < 0) ? -$signed(q) : $signed(q);
    endfunction

    localparam t_log_tab  LOG_TAB  = build_log_tab();
    localparam t_root_tab ROOT_TAB = build_root_tab();

    logic signed [SB-1:0] r_main, r_det;
    logic [P_W-1:0]       r_p;
    logic [31:0]          r_frac;
    logic                 r_zero;
    logic signed [67:0]   r_prod;
    logic signed [33:0]   m_a, m_b;
    logic                 mul_en;
    logic [IDX_W-1:0]     r_idx, rom_addr;
    logic [31:0]          r_rem;
    logic [16:0]          r_rom, r_t0;
    logic signed [23:0]   r_l2;
    logic signed [17:0]   r_d;
    logic signed [18:0]   r_s, r_hard;
    logic [29:0]          r_oq;
    logic [57:0]          r_acc;
    logic [31:0]          r_peak, r_sm;
    logic [6:0]           r_ip;
    logic [15:0]          r_fp;
    logic [30:0]          r_g;
    logic [32:0]          r_tv;
    logic signed [SB-1:0] r_out_sample;
    logic [GR_W-1:0]      r_out_gr;

    logic [SB-1:0]        ax, mag;
    logic [P_W-1:0]       lead;
    logic [SB+31:0]       frac_sh;
    logic signed [23:0]   pexp;
    logic signed [67:0]   db, knee, o68;
    logic signed [14:0]   db_c;
    logic [16:0]          r_eff;
    logic signed [18:0]   twod, wn;
    logic [13:0]          o14;
    logic [24:0]          rc_c, ac_c;
    logic [57:0]          sm_sum;
    logic [33:0]          sm_y;
    logic                 fbit;
    logic [6:0]           sh_amt;
    logic [67:0]          tv_full, u;
    logic [SB-1:0]        lim;
    logic                 neg;
    logic [32:0]          gr_sum;

    assign ax   = r_det[SB-1] ? SB'(~r_det + 1'b1) : SB'(r_det);
    assign mag  = r_main[SB-1] ? SB'(~r_main + 1'b1) : SB'(r_main);
    assign neg  = r_main[SB-1];
    assign fbit = r_fp[4'(5'd16 - i_cmd.k)];

    always_comb begin
        lead = '0;
        for (int i = 0; i < SB; i++) begin
            if (ax[i]) lead = P_W'(i);
        end
    end

    assign frac_sh = {ax, 32'd0} >> lead;
    assign pexp    = 24'(r_p) - 24'(SB - 1);
    assign db      = rnd(r_prod, 32);
    assign r_eff   = (i_cfg.inv_ratio > 17'd65536) ? 17'd65536 : i_cfg.inv_ratio;
    assign twod    = 19'(r_d) <<< 1;
    assign wn      = $signed({6'd0, i_cfg.knee_width});
    assign knee    = -rnd(r_prod, 26);
    assign rc_c    = 25'h100_0000 - {1'b0, i_cfg.release_c};
    assign ac_c    = 25'h100_0000 - {1'b0, i_cfg.attack};
    assign sm_sum  = r_acc + 58'(r_prod[56:0]) + 58'h80_0000;
    assign sm_y    = sm_sum[57:24];
    assign sh_amt  = r_ip + 7'd30;
    assign tv_full = (68'(r_prod) + (68'd1 << (sh_amt - 7'd1))) >> sh_amt;
    assign u       = (68'(r_prod) + 68'h2_0000) >> 18;
    assign lim     = neg ? SB'(1) << (SB - 1) : (SB'(1) << (SB - 1)) - SB'(1);
    assign gr_sum  = {1'b0, r_sm} + 33'h8000;

    always_comb begin
        if (db < 68'sd0 - 68'(-LEVEL_FLOOR)) begin
            db_c = 15'(LEVEL_FLOOR);
        end else if (db > 68'sd0) begin
            db_c = '0;
        end else begin
            db_c = 15'(db);
        end
        if (twod < -wn) begin
            o68 = '0;
        end else if (twod > wn) begin
            o68 = 68'(r_hard);
        end else begin
            o68 = knee;
        end
        if (o68 < 0) begin
            o14 = '0;
        end else if (o68 > 68'sd16383) begin
            o14 = 14'(MAX_REDUCTION);
        end else begin
            o14 = 14'(o68);
        end
    end

    always_comb begin
        mul_en   = 1'b0;
        m_a      = '0;
        m_b      = '0;
        rom_addr = '0;
        case (i_cmd.op)
            OP_POS: begin
                mul_en = 1'b1;
                m_a    = $signed({2'b0, r_frac});
                m_b    = 34'sd0 + 34'(LOG_TABLE_ENTRIES);
            end
            OP_TAB0: rom_addr = r_prod[32 +: IDX_W];
            OP_TAB1: rom_addr = r_idx + 1'b1;
            OP_INTERP: begin
                mul_en = 1'b1;
                m_a    = $signed(34'(r_rom - r_t0));
                m_b    = $signed({2'b0, r_rem});
            end
            OP_DB: begin
                mul_en = 1'b1;
                m_a    = 34'(r_l2);
                m_b    = 34'sd0 + 34'(DB_PER_LOG2_Q32);
            end
            OP_CV1: begin
                mul_en = 1'b1;
                m_a    = 34'(r_d);
                m_b    = $signed({17'd0, r_eff});
            end
            OP_CV2: begin
                mul_en = 1'b1;
                m_a    = 34'(r_s);
                m_b    = 34'(r_s);
            end
            OP_CV3: begin
                mul_en = 1'b1;
                m_a    = 34'(i_cfg.knee_coeff);
                m_b    = $signed(r_prod[33:0]);
            end
            OP_PK1: begin
                mul_en = 1'b1;
                m_a    = $signed({10'd0, i_cfg.release_c});
                m_b    = $signed({2'd0, r_peak});
            end
            OP_PK2: begin
                mul_en = 1'b1;
                m_a    = $signed({9'd0, rc_c});
                m_b    = $signed({4'd0, r_oq});
            end
            OP_AT1: begin
                mul_en = 1'b1;
                m_a    = $signed({10'd0, i_cfg.attack});
                m_b    = $signed({2'd0, r_sm});
            end
            OP_AT2: begin
                mul_en = 1'b1;
                m_a    = $signed({9'd0, ac_c});
                m_b    = $signed({2'd0, r_peak});
            end
            OP_GA1: begin
                mul_en = 1'b1;
                m_a    = $signed({2'd0, r_sm});
                m_b    = 34'sd0 + 34'(LOG2_PER_DB_Q32);
            end
            OP_EXPM: begin
                mul_en = fbit;
                m_a    = $signed({3'd0, r_g});
                m_b    = $signed({3'd0, ROOT_TAB[i_cmd.k]});
            end
            OP_SC1: begin
                mul_en = 1'b1;
                m_a    = $signed(34'(mag));
                m_b    = $signed({3'd0, r_g});
            end
            OP_SC3: begin
                mul_en = 1'b1;
                m_a    = $signed({1'b0, r_tv});
                m_b    = $signed({10'd0, i_cfg.makeup});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rom <= LOG_TAB[rom_addr];
        if (mul_en) r_prod <= m_a * m_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_sm   <= '0;
        end else begin
            if (i_cmd.op == OP_PK3) begin
                r_peak <= (sm_y < {4'd0, r_oq}) ? {2'd0, r_oq} : sm_y[31:0];
            end
            if (i_cmd.op == OP_AT3) r_sm <= sm_y[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_main <= i_main_sample;
            r_det  <= i_cfg.use_sc ? i_sidechain_sample : i_main_sample;
        end
        case (i_cmd.op)
            OP_NORM: begin
                r_zero <= (ax == '0);
                r_p    <= lead;
                r_frac <= frac_sh[31:0];
            end
            OP_TAB0: begin
                r_idx <= r_prod[32 +: IDX_W];
                r_rem <= r_prod[31:0];
            end
            OP_TAB1: r_t0 <= r_rom;
            OP_L2:   r_l2 <= (pexp <<< 16) + 24'(r_t0) + 24'(r_prod[48:32]);
            OP_LVL: begin
                if (r_zero) begin
                    r_d <= 18'(LEVEL_FLOOR) - 18'(i_cfg.threshold);
                end else begin
                    r_d <= 18'(db_c) - 18'(i_cfg.threshold);
                end
            end
            OP_CV1:  r_s <= twod + wn;
            OP_CV2:  r_hard <= 19'(r_d) - 19'(rnd(r_prod, 16));
            OP_CV4:  r_oq <= {o14, 16'd0};
            OP_PK2:  r_acc <= 58'(r_prod[56:0]);
            OP_AT2:  r_acc <= 58'(r_prod[56:0]);
            OP_GA2: begin
                r_ip <= r_prod[54:48];
                r_fp <= r_prod[47:32];
                r_g  <= 31'h4000_0000;
            end
            OP_EXPR: begin
                if (fbit) r_g <= 31'((68'(r_prod) + 68'h2000_0000) >> 30);
            end
            OP_SC2:  r_tv <= (r_ip >= 7'd33) ? '0 : 33'(tv_full);
            OP_FIN: begin
                if (u > 68'(lim)) begin
                    r_out_sample <= neg ? $signed(SB'(~lim + 1'b1)) : $signed(lim);
                end else begin
                    r_out_sample <= neg ? $signed(SB'(~u[SB-1:0] + 1'b1))
                                        : $signed(u[SB-1:0]);
                end
                r_out_gr <= (gr_sum[32:16] > 17'(MAX_REDUCTION)) ? GR_W'(MAX_REDUCTION)
                                                                 : GR_W'(gr_sum[32:16]);
            end
            default: begin
            end
        endcase
    end

    assign o_out_sample        = r_out_sample;
    assign o_gain_reduction_db = r_out_gr;

endmodule

// ----- sv/audio_dynamic_range_compressor_top.sv -----
// Top level of the audio dynamic range compressor: register file, sequencer and datapath.
// One item (main and sidechain sample) gives one result. The sequencer accepts it, runs
// twenty front steps for level detection, static curve, the two smoothing filters and the
// split of the gain, then the sixteen root products of the fractional gain, three steps
// for sample scaling and a final step that writes the result register. All multiplies run
// through a single shared 34x34 multiplier. A new item is taken once the previous one has
// reached the result register, which then waits for the consumer while the next item is worked on.
module audio_dynamic_range_compressor_top #(
    parameter int SAMPLE_BITS       = adrc_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_ENTRIES = adrc_pkg::LOG_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_main_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_sidechain_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_out_sample,
    output logic [adrc_pkg::GR_W-1:0]         o_gain_reduction_db
);
    import adrc_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_sc     <= 1'b0;
            r_cfg.threshold  <= '0;
            r_cfg.inv_ratio  <= 17'd65536;
            r_cfg.knee_width <= 13'd1;
            r_cfg.knee_coeff <= '0;
            r_cfg.attack     <= '0;
            r_cfg.release_c  <= '0;
            r_cfg.makeup     <= 24'd262144;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_USE_SC:     r_cfg.use_sc     <= i_cfg_data[0];
                REG_THRESHOLD:  r_cfg.threshold  <= $signed(i_cfg_data[14:0]);
                REG_INV_RATIO:  r_cfg.inv_ratio  <= i_cfg_data[16:0];
                REG_KNEE_WIDTH: r_cfg.knee_width <= i_cfg_data[12:0];
                REG_KNEE_COEFF: r_cfg.knee_coeff <= $signed(i_cfg_data);
                REG_ATTACK:     r_cfg.attack     <= i_cfg_data;
                REG_RELEASE:    r_cfg.release_c  <= i_cfg_data;
                REG_MAKEUP:     r_cfg.makeup     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    adrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    adrc_dp #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg               (r_cfg),
        .i_main_sample       (i_main_sample),
        .i_sidechain_sample  (i_sidechain_sample),
        .o_out_sample        (o_out_sample),
        .o_gain_reduction_db (o_gain_reduction_db)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the audio dynamic range compressor top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import adrc_pkg::*;

    localparam int  SB        = SAMPLE_BITS_DEF;
    localparam int  LOG_N     = LOG_ENTRIES_DEF;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int  DRAIN_WAIT = 80;

    typedef struct {
        logic signed [SB-1:0] smp;
        logic [GR_W-1:0]      gr;
    } comp_result_t;

    typedef struct {
        int                   cfg_sel;
        logic signed [SB-1:0] mn;
        logic signed [SB-1:0] sc;
        bit                   typed;
        logic signed [SB-1:0] e_smp;
        logic [GR_W-1:0]      e_gr;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [SB-1:0]  i_main_sample;
    logic signed [SB-1:0]  i_sidechain_sample;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [SB-1:0]  o_out_sample;
    logic [GR_W-1:0]       o_gain_reduction_db;

    audio_dynamic_range_compressor_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_main_sample       (i_main_sample),
        .i_sidechain_sample  (i_sidechain_sample),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_sample        (o_out_sample),
        .o_gain_reduction_db (o_gain_reduction_db)
    );

    // predictor state
    longint unsigned log_tab [0:LOG_N];
    longint unsigned root_tab [0:16];
    t_cfg            model_cfg;
    longint unsigned peak_q16;
    longint unsigned smooth_q16;

    comp_result_t expected_q [$];
    int           err_cnt;
    longint       cycle_cnt;
    int           send_idle;
    int           recv_idle;
    int           hold_left;
    bit           typed_flag;
    comp_result_t typed_res;

    function automatic longint round_shr(longint v, int s);
        longint unsigned half;
        half = 64'd1 << (s - 1);
        if (v >= 0) return longint'((unsigned'(v) + half) >> s);
        return -longint'((unsigned'(-v) + half) >> s);
    endfunction

    function automatic longint level_in_db(longint x);
        longint unsigned ax, frac, pos, rem;
        int unsigned     p, idx;
        longint          l2, db;
        ax = (x < 0) ? unsigned'(-x) : unsigned'(x);
        if (ax == 0) return LEVEL_FLOOR;
        p = 0;
        while ((ax >> (p + 1)) != 0) p++;
        frac = (ax - (64'd1 << p)) << (32 - p);
        pos  = frac * LOG_N;
        idx  = int'(pos >> 32);
        rem  = pos & 64'hFFFF_FFFF;
        l2 = (longint'(p) - (SB - 1)) * 65536 + longint'(log_tab[idx])
           + longint'(((log_tab[idx+1] - log_tab[idx]) * rem) >> 32);
        db = round_shr(l2 * DB_PER_LOG2_Q32, 32);
        if (db < LEVEL_FLOOR) db = LEVEL_FLOOR;
        if (db > 0) db = 0;
        return db;
    endfunction

    function automatic comp_result_t compress_predict(logic signed [SB-1:0] mn,
                                                      logic signed [SB-1:0] sc);
        longint          mv, lvl, t, w, kc, r, d, o, s;
        longint unsigned oq, y1, yl, a, g, mag, tv, u, lim, gr;
        longint unsigned rc, ac, mk;
        int unsigned     ip, fp;
        bit              neg;
        comp_result_t    res;
        mv  = mn;
        lvl = model_cfg.use_sc ? level_in_db(sc) : level_in_db(mn);
        t   = longint'($signed(model_cfg.threshold));
        w   = longint'(model_cfg.knee_width);
        kc  = longint'($signed(model_cfg.knee_coeff));
        r   = (model_cfg.inv_ratio > 17'd65536) ? 65536 : longint'(model_cfg.inv_ratio);
        d   = lvl - t;
        if (2 * d < -w) begin
            o = 0;
        end else if (2 * d > w) begin
            o = d - round_shr(d * r, 16);
        end else begin
            s = 2 * d + w;
            o = -round_shr(kc * s * s, 26);
        end
        if (o < 0) o = 0;
        if (o > MAX_REDUCTION) o = MAX_REDUCTION;
        oq = unsigned'(o) << 16;
        rc = model_cfg.release_c;
        ac = model_cfg.attack;
        mk = model_cfg.makeup;
        y1 = (rc * peak_q16 + (64'h100_0000 - rc) * oq + 64'h80_0000) >> 24;
        if (y1 < oq) y1 = oq;
        yl = (ac * smooth_q16 + (64'h100_0000 - ac) * y1 + 64'h80_0000) >> 24;
        peak_q16   = y1;
        smooth_q16 = yl;
        a  = (yl * LOG2_PER_DB_Q32) >> 32;
        ip = int'(a >> 16);
        fp = int'(a & 64'hFFFF);
        g  = 64'd1 << 30;
        for (int k = 1; k <= EXP_STEPS; k++)
            if (((fp >> (16 - k)) & 1) != 0)
                g = (g * root_tab[k] + (64'd1 << 29)) >> 30;
        neg = mv < 0;
        mag = neg ? unsigned'(-mv) : unsigned'(mv);
        if (ip + 30 >= 63) tv = 0;
        else tv = (mag * g + (64'd1 << (29 + ip))) >> (30 + ip);
        u   = (tv * mk + (64'd1 << 17)) >> 18;
        lim = neg ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 1);
        if (u > lim) u = lim;
        res.smp = SB'(neg ? (64'd0 - u) : u);
        gr = (yl + 64'h8000) >> 16;
        if (gr > MAX_REDUCTION) gr = MAX_REDUCTION;
        res.gr = gr[GR_W-1:0];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("audio_dynamic_range_compressor_top regression: fail");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    comp_result_t mon_pred, mon_exp;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                mon_pred = compress_predict(i_main_sample, i_sidechain_sample);
                expected_q.push_back(typed_flag ? typed_res : mon_pred);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected item: sample %0d gr %0d",
                                 o_out_sample, o_gain_reduction_db);
                end else begin
                    mon_exp = expected_q.pop_front();
                    if (o_out_sample !== mon_exp.smp || o_gain_reduction_db !== mon_exp.gr) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: sample exp %0d got %0d, gr exp %0d got %0d",
                                     mon_exp.smp, o_out_sample, mon_exp.gr,
                                     o_gain_reduction_db);
                    end
                end
            end
        end
    end

    task automatic write_reg(t_reg idx, longint unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        case (idx)
            REG_USE_SC:     model_cfg.use_sc     = val[0];
            REG_THRESHOLD:  model_cfg.threshold  = val[14:0];
            REG_INV_RATIO:  model_cfg.inv_ratio  = val[16:0];
            REG_KNEE_WIDTH: model_cfg.knee_width = val[12:0];
            REG_KNEE_COEFF: model_cfg.knee_coeff = val[23:0];
            REG_ATTACK:     model_cfg.attack     = val[23:0];
            REG_RELEASE:    model_cfg.release_c  = val[23:0];
            REG_MAKEUP:     model_cfg.makeup     = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_all(t_cfg c);
        write_reg(REG_USE_SC,     c.use_sc);
        write_reg(REG_THRESHOLD,  c.threshold);
        write_reg(REG_INV_RATIO,  c.inv_ratio);
        write_reg(REG_KNEE_WIDTH, c.knee_width);
        write_reg(REG_KNEE_COEFF, c.knee_coeff);
        write_reg(REG_ATTACK,     c.attack);
        write_reg(REG_RELEASE,    c.release_c);
        write_reg(REG_MAKEUP,     c.makeup);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic signed [SB-1:0] mn, logic signed [SB-1:0] sc,
                             bit typed, comp_result_t tr);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            while ($urandom_range(99) < send_idle) @(negedge i_clk);
            @(negedge i_clk);
        end
        typed_flag         = typed;
        typed_res          = tr;
        i_main_sample      = mn;
        i_sidechain_sample = sc;
        i_in_valid         = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(9) == 0) return SB'(v);
        v = v >> (8 + $urandom_range(0, 23));
        return $urandom_range(1) ? -SB'(v) : SB'(v);
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg   c;
        longint rr, ww;
        c.use_sc = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: c.threshold = 15'h4000;
            1: c.threshold = 15'h3FFF;
            2: c.threshold = '0;
            default: c.threshold = 15'(-$urandom_range(0, 10240));
        endcase
        c.inv_ratio = ($urandom_range(7) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 65536));
        case ($urandom_range(9))
            0: c.knee_width = '0;
            1: c.knee_width = 13'h1FFF;
            default: c.knee_width = 13'($urandom_range(1, 4096));
        endcase
        rr = (c.inv_ratio > 17'd65536) ? 65536 : longint'(c.inv_ratio);
        ww = (c.knee_width == 0) ? 1 : longint'(c.knee_width);
        c.knee_coeff = ($urandom_range(5) == 0) ? 24'($urandom)
                                                : 24'(((rr - 65536) * 256) / (2 * ww));
        c.attack    = ($urandom_range(3) == 0) ? 24'($urandom)
                                               : 24'hFF_FFFF - 24'($urandom_range(0, 60000));
        c.release_c = ($urandom_range(3) == 0) ? 24'($urandom)
                                               : 24'hFF_FFFF - 24'($urandom_range(0, 5000));
        c.makeup    = ($urandom_range(4) == 0) ? 24'($urandom)
                                               : 24'($urandom_range(131072, 1048576));
        return c;
    endfunction

    t_cfg         dir_cfg [5];
    dir_row_t     dir_tab [$];
    comp_result_t no_res;
    int           cur_cfg;

    initial begin
        longint unsigned v, n, rs, bt;
        longint unsigned lr;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_main_sample = '0;
        i_sidechain_sample = '0;
        typed_flag = 1'b0;
        hold_left = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        send_idle = 25;
        recv_idle = 67;
        no_res = '{smp: '0, gr: '0};

        for (int i = 0; i < LOG_N; i++) begin
            v  = (64'd1 << 30) + ((64'(i) << 30) / LOG_N);
            lr = 0;
            for (int b = 15; b >= 0; b--) begin
                v = (v * v) >> 30;
                if (v >= (64'd1 << 31)) begin
                    v = v >> 1;
                    lr |= 64'd1 << b;
                end
            end
            log_tab[i] = lr;
        end
        log_tab[LOG_N] = 65536;
        root_tab[0] = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            n  = root_tab[i-1] << 30;
            rs = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt = bt >> 2;
            while (bt != 0) begin
                if (n >= rs + bt) begin
                    n  = n - (rs + bt);
                    rs = (rs >> 1) + bt;
                end else begin
                    rs = rs >> 1;
                end
                bt = bt >> 2;
            end
            root_tab[i] = rs;
        end
        model_cfg = '{use_sc: 1'b0, threshold: '0, inv_ratio: 17'd65536, knee_width: 13'd1,
                      knee_coeff: '0, attack: '0, release_c: '0, makeup: 24'd262144};
        peak_q16   = 0;
        smooth_q16 = 0;

        dir_cfg[0] = model_cfg;
        // ratio 4 with a soft knee around -20 dB
        dir_cfg[1] = '{use_sc: 1'b0, threshold: 15'(-1280), inv_ratio: 17'd16384,
                       knee_width: 13'd384, knee_coeff: 24'(-16384), attack: '0,
                       release_c: '0, makeup: 24'd262144};
        // lowest threshold, infinite ratio, no knee, full makeup, sidechain detect
        dir_cfg[2] = '{use_sc: 1'b1, threshold: 15'h4000, inv_ratio: '0, knee_width: '0,
                       knee_coeff: '0, attack: '0, release_c: '0, makeup: 24'hFF_FFFF};
        dir_cfg[3] = '{use_sc: 1'b1, threshold: '0, inv_ratio: '0, knee_width: '0,
                       knee_coeff: 24'h80_0000, attack: '0, release_c: '0,
                       makeup: 24'hFF_FFFF};
        // inverse ratio above one (clamped to a ratio of one), widest knee, positive knee slope, slowest filters
        dir_cfg[4] = '{use_sc: 1'b0, threshold: 15'(-5000), inv_ratio: 17'h1FFFF,
                       knee_width: 13'h1FFF, knee_coeff: 24'h7F_FFFF, attack: 24'hFF_FFFF,
                       release_c: 24'hFF_FFFF, makeup: 24'd262144};

        dir_tab = '{
            '{0,  24'sh7FFFFF, 24'sh000000, 1, 24'sh7FFFFF, 14'd0},
            '{0, -24'sh800000, 24'sh000005, 1, -24'sh800000, 14'd0},
            '{0,  24'sh000000, 24'sh000000, 1, 24'sh000000, 14'd0},
            '{0, -24'sh000001, -24'sh000001, 1, -24'sh000001, 14'd0},
            '{0,  24'sh000001, -24'sh800000, 1, 24'sh000001, 14'd0},
            '{1,  24'sh7FFFFF, 24'sh0, 0, '0, '0},
            '{1, -24'sh400000, 24'sh0, 0, '0, '0},
            '{1,  24'sh0CCCCD, 24'sh0, 0, '0, '0},
            '{1,  24'sh0C3500, 24'sh0, 0, '0, '0},
            '{1, -24'sh0DBBA0, 24'sh0, 0, '0, '0},
            '{1,  24'sh0186A0, 24'sh0, 0, '0, '0},
            '{1,  24'sh000000, 24'sh0, 0, '0, '0},
            '{2,  24'sh0186A0, 24'sh7FFFFF, 1, 24'sh000000, 14'd16383},
            '{2,  24'sh7FFFFF, 24'sh000000, 0, '0, '0},
            '{2, -24'sh000003, -24'sh000001, 0, '0, '0},
            '{3,  24'sh0003E8, -24'sh800000, 0, '0, '0},
            '{3,  24'sh7FFFFF, -24'sh800000, 1, 24'sh7FFFFF, 14'd0},
            '{3, -24'sh800000, -24'sh800000, 1, -24'sh800000, 14'd0},
            '{3,  24'sh000100, 24'sh000001, 0, '0, '0},
            '{4,  24'sh7FFFFF, 24'sh0, 0, '0, '0},
            '{4,  24'sh03E800, 24'sh0, 0, '0, '0},
            '{4, -24'sh0A0000, 24'sh0, 0, '0, '0},
            '{4,  24'sh001000, 24'sh0, 0, '0, '0}
        };

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_cfg = 0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg_sel != cur_cfg) begin
                i_in_valid = 1'b0;
                drain();
                cur_cfg = dir_tab[i].cfg_sel;
                program_all(dir_cfg[cur_cfg]);
            end
            send_item(dir_tab[i].mn, dir_tab[i].sc, dir_tab[i].typed,
                      '{smp: dir_tab[i].e_smp, gr: dir_tab[i].e_gr});
        end

        for (int ph = 0; ph < 6; ph++) begin
            i_in_valid = 1'b0;
            drain();
            send_idle = (ph < 2) ? 25 : (ph < 4) ? 67 : 0;
            recv_idle = (ph < 2) ? 67 : (ph < 4) ? 25 : 0;
            program_all(rand_cfg());
            if (ph == 1 || ph == 4) hold_left = 400;
            for (int k = 0; k < 165; k++) begin
                if (k == 80) begin
                    i_in_valid = 1'b0;
                    while (expected_q.size() != 0) @(negedge i_clk);
                end
                send_item(rand_sample(), ($urandom_range(3) == 0) ? i_main_sample
                                                                  : rand_sample(),
                          1'b0, no_res);
            end
        end

        i_in_valid = 1'b0;
        drain();
        if (err_cnt == 0)
            $display("audio_dynamic_range_compressor_top regression: pass");
        else
            $display("audio_dynamic_range_compressor_top regression: fail");
        $finish;
    end

endmodule
